// File: rtl/core/bbt_pkg.sv
`default_nettype none

package bbt_pkg;

    // Default bar counter width; the top level may narrow it.
    localparam int BBT_BAR_WIDTH = 32;

    // Field and register widths.
    localparam int TEMPO_W   = 10;
    localparam int TPB_W     = 16;
    localparam int BPB_W     = 6;
    localparam int SR_W      = 19;
    localparam int CFG_W     = 19;
    localparam int CFG_IDX_W = 2;
    localparam int FRAME_W   = 32;
    localparam int NFR_W     = 16;
    localparam int BAR_OUT_W = 32;
    localparam int START_W   = 48;

    // The divisor is at most sample_rate * 60, and the widest product is
    // frame * tempo * ticks_per_beat.
    localparam int DEN_W  = SR_W + 6;
    localparam int PROD_W = FRAME_W + TEMPO_W + TPB_W;

    // Shift-add multiply walks a 16-bit multiplier; restoring divide walks
    // every dividend bit.
    localparam int MUL_STEPS = 16;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        BBT_REG_TEMPO = 2'd0,
        BBT_REG_TPB   = 2'd1,
        BBT_REG_BPB   = 2'd2,
        BBT_REG_SR    = 2'd3
    } bbt_reg_idx_t;

    // Register reset values.
    localparam logic [TEMPO_W-1:0] TEMPO_RST = 10'd120;
    localparam logic [TPB_W-1:0]   TPB_RST   = 16'd1920;
    localparam logic [BPB_W-1:0]   BPB_RST   = 6'd4;
    localparam logic [SR_W-1:0]    SR_RST    = 19'd48000;

    typedef enum logic [0:0] {
        BBT_OP_MUL = 1'b0,
        BBT_OP_DIV = 1'b1
    } bbt_op_t;

    // Request to the shared arithmetic unit. A multiply uses the low
    // MUL_STEPS bits of b as the multiplier.
    typedef struct packed {
        logic              start;
        bbt_op_t           op;
        logic [PROD_W-1:0] a;
        logic [DEN_W-1:0]  b;
    } bbt_alu_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] result;
        logic [DEN_W-1:0]  rem;
    } bbt_alu_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/bbt_stream_if.sv
`default_nettype none

interface bbt_in_if
    import bbt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [FRAME_W-1:0] abs_frame;
    logic [NFR_W-1:0]   period_frames;

    modport source (output valid, output cmd, output abs_frame, output period_frames,
                    input ready);
    modport sink   (input valid, input cmd, input abs_frame, input period_frames,
                    output ready);
endinterface

interface bbt_out_if
    import bbt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BAR_OUT_W-1:0] bar_number;
    logic [BPB_W-1:0]     beat_number;
    logic [TPB_W-1:0]     tick_number;
    logic [START_W-1:0]   bar_start;
    logic                 resynced;

    modport source (output valid, output bar_number, output beat_number,
                    output tick_number, output bar_start, output resynced,
                    input ready);
    modport sink   (input valid, input bar_number, input beat_number,
                    input tick_number, input bar_start, input resynced,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/bbt_alu.sv
`default_nettype none

// Shared multiply and divide unit, one bit per cycle.
module bbt_alu
    import bbt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire bbt_alu_req_t req,
    output bbt_alu_rsp_t      rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    bbt_op_t           op_reg, op_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [MUL_STEPS-1:0] mplier_reg, mplier_next;
    logic [DEN_W-1:0]  divisor_reg, divisor_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;

    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              fits;

    always_comb
    begin
        shifted = {rem_reg, acc_reg[PROD_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        fits    = shifted >= {1'b0, divisor_reg};

        busy_next    = busy_reg;
        done_next    = 1'b0;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;

        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            if (req.op == BBT_OP_MUL)
            begin
                cnt_next    = STEP_W'(MUL_STEPS - 1);
                acc_next    = '0;
                mcand_next  = req.a;
                mplier_next = req.b[MUL_STEPS-1:0];
            end
            else
            begin
                cnt_next     = STEP_W'(DIV_STEPS - 1);
                acc_next     = req.a;
                rem_next     = '0;
                divisor_next = req.b;
            end
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                BBT_OP_MUL:
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                    mplier_next = mplier_reg >> 1;
                end
                BBT_OP_DIV:
                begin
                    acc_next = {acc_reg[PROD_W-2:0], fits};
                    rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                end
            endcase
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= BBT_OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;
    assign rsp.rem    = rem_reg;

endmodule

`default_nettype wire

// File: rtl/core/bar_beat_tick_tracker_top.sv
// Words are handled one at a time: the input is ready only while the sequencer is idle,
// so a new word enters only after the last result has moved to the output register.
// Every multiply and divide runs on the single shared shift-add / restoring-divide unit.
// Reset (asynchronous, active low) loads the register defaults, sets the position to
// bar 1 beat 1 tick 0 and arms a resync for the first word.
`default_nettype none

module bar_beat_tick_tracker_top
    import bbt_pkg::*;
#(
    parameter int BAR_WIDTH = BBT_BAR_WIDTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    bbt_in_if.sink                    in_ch,
    bbt_out_if.source                 out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // The sequencer walks one arithmetic step per state. A resync runs
    // MUL_A, MUL_B, DIV_T, DIV_B, DIV_C, MUL_C; an advance runs the same
    // chain plus MUL_D, and stops after DIV_B when no whole beat was gained.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL_A = 9'b000000010,
        S_MUL_B = 9'b000000100,
        S_DIV_T = 9'b000001000,
        S_DIV_B = 9'b000010000,
        S_DIV_C = 9'b000100000,
        S_MUL_C = 9'b001000000,
        S_MUL_D = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [TEMPO_W-1:0] tempo_reg, tempo_next;
    logic [TPB_W-1:0]   tpb_reg, tpb_next;
    logic [BPB_W-1:0]   bpb_reg, bpb_next;
    logic [SR_W-1:0]    sr_reg, sr_next;

    // Musical position.
    logic                 pending_reg, pending_next;
    logic [BAR_WIDTH-1:0] bar_reg, bar_next;
    logic [BPB_W-1:0]     beat_reg, beat_next;
    logic [TPB_W-1:0]     tick_reg, tick_next;
    logic [START_W-1:0]   start_reg, start_next;

    // Per-word working state.
    logic              resync_reg, resync_next;
    logic              extra_reg, extra_next;
    logic [PROD_W-1:0] work_reg, work_next;

    // Output register, which lets the result wait while the core idles.
    logic                 out_valid_reg, out_valid_next;
    logic [BAR_WIDTH-1:0] out_bar_reg, out_bar_next;
    logic [BPB_W-1:0]     out_beat_reg, out_beat_next;
    logic [TPB_W-1:0]     out_tick_reg, out_tick_next;
    logic [START_W-1:0]   out_start_reg, out_start_next;
    logic                 out_resync_reg, out_resync_next;

    bbt_alu_req_t alu_req;
    bbt_alu_rsp_t alu_rsp;

    // A zero divisor register acts as one.
    logic [TPB_W-1:0]  tpb1;
    logic [BPB_W-1:0]  bpb1;
    logic [SR_W-1:0]   sr1;
    logic [DEN_W-1:0]  denom;
    logic              accept;
    logic              resync_in;
    logic              over;
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] pos;
    logic [PROD_W-1:0] bars;

    bbt_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign tpb1  = (tpb_reg == '0) ? TPB_W'(1) : tpb_reg;
    assign bpb1  = (bpb_reg == '0) ? BPB_W'(1) : bpb_reg;
    assign sr1   = (sr_reg == '0) ? SR_W'(1) : sr_reg;
    // Frames per minute: sample_rate * 60 as (x << 6) - (x << 2).
    assign denom = (DEN_W'(sr1) << 6) - (DEN_W'(sr1) << 2);

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign resync_in   = in_ch.cmd || pending_reg;
    assign q           = alu_rsp.result;

    // Carry of whole beats. A beat that lies beyond a shortened bar first
    // wraps to beat one and counts one bar, spending one of the beats.
    assign over = beat_reg > bpb1;
    assign pos  = over ? (q - PROD_W'(1)) : (q + PROD_W'(beat_reg) - PROD_W'(1));
    assign bars = q + PROD_W'(extra_reg);

    always_comb
    begin
        state_next      = state_reg;
        tempo_next      = tempo_reg;
        tpb_next        = tpb_reg;
        bpb_next        = bpb_reg;
        sr_next         = sr_reg;
        pending_next    = pending_reg;
        bar_next        = bar_reg;
        beat_next       = beat_reg;
        tick_next       = tick_reg;
        start_next      = start_reg;
        resync_next     = resync_reg;
        extra_next      = extra_reg;
        work_next       = work_reg;
        out_valid_next  = (out_valid_reg && out_ch.ready) ? 1'b0 : out_valid_reg;
        out_bar_next    = out_bar_reg;
        out_beat_next   = out_beat_reg;
        out_tick_next   = out_tick_reg;
        out_start_next  = out_start_reg;
        out_resync_next = out_resync_reg;

        alu_req.start = 1'b0;
        alu_req.op    = BBT_OP_MUL;
        alu_req.a     = '0;
        alu_req.b     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Both paths scale a frame count by tempo, then by ticks.
                    resync_next   = resync_in;
                    if (resync_in)
                    begin
                        pending_next = 1'b0;
                    end
                    alu_req.start = 1'b1;
                    alu_req.op    = BBT_OP_MUL;
                    alu_req.a     = resync_in ? PROD_W'(in_ch.abs_frame)
                                              : PROD_W'(in_ch.period_frames);
                    alu_req.b     = DEN_W'(tempo_reg);
                    state_next    = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = BBT_OP_MUL;
                    alu_req.a     = q;
                    alu_req.b     = DEN_W'(tpb1);
                    state_next    = S_MUL_B;
                end
            end
            S_MUL_B:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = BBT_OP_DIV;
                    alu_req.a     = q;
                    alu_req.b     = denom;
                    state_next    = S_DIV_T;
                end
            end
            S_DIV_T:
            begin
                if (alu_rsp.done)
                begin
                    // Resync splits the absolute tick; advance adds the new
                    // ticks to the tick already held.
                    alu_req.start = 1'b1;
                    alu_req.op    = BBT_OP_DIV;
                    alu_req.a     = resync_reg ? q : (q + PROD_W'(tick_reg));
                    alu_req.b     = DEN_W'(tpb1);
                    state_next    = S_DIV_B;
                end
            end
            S_DIV_B:
            begin
                if (alu_rsp.done)
                begin
                    tick_next = alu_rsp.rem[TPB_W-1:0];
                    if (resync_reg)
                    begin
                        work_next     = q;
                        alu_req.start = 1'b1;
                        alu_req.op    = BBT_OP_DIV;
                        alu_req.a     = q;
                        alu_req.b     = DEN_W'(bpb1);
                        state_next    = S_DIV_C;
                    end
                    else if (q == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        extra_next    = over;
                        alu_req.start = 1'b1;
                        alu_req.op    = BBT_OP_DIV;
                        alu_req.a     = pos;
                        alu_req.b     = DEN_W'(bpb1);
                        state_next    = S_DIV_C;
                    end
                end
            end
            S_DIV_C:
            begin
                if (alu_rsp.done)
                begin
                    beat_next     = alu_rsp.rem[BPB_W-1:0] + BPB_W'(1);
                    alu_req.start = 1'b1;
                    alu_req.op    = BBT_OP_MUL;
                    alu_req.b     = DEN_W'(resync_reg ? DEN_W'(tpb1) : DEN_W'(bpb1));
                    if (resync_reg)
                    begin
                        // The bar starts at the first beat of the bar, in ticks.
                        bar_next  = q[BAR_WIDTH-1:0] + BAR_WIDTH'(1);
                        alu_req.a = work_reg - PROD_W'(alu_rsp.rem);
                    end
                    else
                    begin
                        bar_next  = bar_reg + bars[BAR_WIDTH-1:0];
                        alu_req.a = bars;
                    end
                    state_next = S_MUL_C;
                end
            end
            S_MUL_C:
            begin
                if (alu_rsp.done)
                begin
                    if (resync_reg)
                    begin
                        start_next = q[START_W-1:0];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = BBT_OP_MUL;
                        alu_req.a     = q;
                        alu_req.b     = DEN_W'(tpb1);
                        state_next    = S_MUL_D;
                    end
                end
            end
            S_MUL_D:
            begin
                if (alu_rsp.done)
                begin
                    start_next = start_reg + q[START_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_bar_next    = bar_reg;
                    out_beat_next   = beat_reg;
                    out_tick_next   = tick_reg;
                    out_start_next  = start_reg;
                    out_resync_next = resync_reg;
                    state_next      = S_IDLE;
                end
            end
        endcase

        // Writes are expected only while the core is idle; a tempo write arms
        // a resync.
        if (cfg_we)
        begin
            unique case (cfg_index)
                BBT_REG_TEMPO:
                begin
                    tempo_next   = cfg_data[TEMPO_W-1:0];
                    pending_next = 1'b1;
                end
                BBT_REG_TPB: tpb_next = cfg_data[TPB_W-1:0];
                BBT_REG_BPB: bpb_next = cfg_data[BPB_W-1:0];
                BBT_REG_SR:  sr_next  = cfg_data[SR_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tempo_reg     <= TEMPO_RST;
            tpb_reg       <= TPB_RST;
            bpb_reg       <= BPB_RST;
            sr_reg        <= SR_RST;
            pending_reg   <= 1'b1;
            bar_reg       <= BAR_WIDTH'(1);
            beat_reg      <= BPB_W'(1);
            tick_reg      <= '0;
            start_reg     <= '0;
            resync_reg    <= 1'b0;
            extra_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tempo_reg     <= tempo_next;
            tpb_reg       <= tpb_next;
            bpb_reg       <= bpb_next;
            sr_reg        <= sr_next;
            pending_reg   <= pending_next;
            bar_reg       <= bar_next;
            beat_reg      <= beat_next;
            tick_reg      <= tick_next;
            start_reg     <= start_next;
            resync_reg    <= resync_next;
            extra_reg     <= extra_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg       <= work_next;
        out_bar_reg    <= out_bar_next;
        out_beat_reg   <= out_beat_next;
        out_tick_reg   <= out_tick_next;
        out_start_reg  <= out_start_next;
        out_resync_reg <= out_resync_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.bar_number  = BAR_OUT_W'(out_bar_reg);
    assign out_ch.beat_number = out_beat_reg;
    assign out_ch.tick_number = out_tick_reg;
    assign out_ch.bar_start   = out_start_reg;
    assign out_ch.resynced    = out_resync_reg;

`ifndef NO_ASSERTIONS
    // The shared unit is always free when a new word may enter.
    a_ready_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !alu_rsp.busy)
        else $error("arithmetic unit busy while input is ready");

    // An accepted word holds the input closed on the next cycle.
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("input ready right after a word was accepted");

    // The unit finishes only inside an arithmetic step of the sequencer.
    a_done_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> ((state_reg != S_IDLE) && (state_reg != S_DONE)))
        else $error("arithmetic result outside a sequencer step");

    // Beats count from one.
    a_beat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.beat_number != '0))
        else $error("beat number zero on a valid result");
`endif

endmodule

`default_nettype wire
